// ----- rtl/core/tlwc_pkg.sv -----
`default_nettype none
package tlwc_pkg;

  // request and result field widths
  localparam int ADDR_W = 20;
  localparam int DATA_W = 32;
  localparam int TIME_W = 32;

  // operation codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // latency register indexes
  localparam logic [2:0] REG_L1_RD  = 3'd0;
  localparam logic [2:0] REG_L1_WR  = 3'd1;
  localparam logic [2:0] REG_L2_RD  = 3'd2;
  localparam logic [2:0] REG_L2_WR  = 3'd3;
  localparam logic [2:0] REG_MEM_RD = 3'd4;
  localparam logic [2:0] REG_MEM_WR = 3'd5;

  // latency reset values
  localparam logic [7:0]  RST_L1_LAT  = 8'd1;
  localparam logic [7:0]  RST_L2_LAT  = 8'd4;
  localparam logic [15:0] RST_MEM_LAT = 16'd100;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [TIME_W-1:0] total_time;
    logic              address_error;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  l1_rd;
    logic [7:0]  l1_wr;
    logic [7:0]  l2_rd;
    logic [7:0]  l2_wr;
    logic [15:0] mem_rd;
    logic [15:0] mem_wr;
  } lat_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_L1_META,
    ST_L1_CHK,
    ST_L2_META,
    ST_L2_CHK,
    ST_COPY,
    ST_L1_OP,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    CP_L1_TO_L2,
    CP_L2_TO_L1,
    CP_L2_TO_MEM,
    CP_MEM_TO_L2
  } copy_t;

endpackage
`default_nettype wire

// ----- rtl/core/two_level_writeback_cache.sv -----
// Two-level write-back cache: direct-mapped L1, 2-way LRU L2, backing memory.
// L1 hit: the result passes through metadata read, tag check and word access states.
// Each L2 lookup adds metadata read and check states, and each block move goes word by word through the
// registered-read data memories; clear and error requests answer in the cycle after they are accepted.
// One request at a time: busy stays high during a read or write walk, until its result strobe is issued.
// After rst_n a clearing pass over 2^(ADDRESS_BITS-2) words zeroes backing memory and L1/L2 metadata.
`default_nettype none
module two_level_writeback_cache #(
  parameter int ADDRESS_BITS = 20,
  parameter int L1_LINES     = 256,
  parameter int L2_SETS      = 512,
  parameter int L2_WAYS      = 2,
  parameter int BLOCK_WORDS  = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire tlwc_pkg::req_t in_req,
  output logic               out_valid,
  output tlwc_pkg::rsp_t     out_rsp,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import tlwc_pkg::*;

  localparam int WAB  = ADDRESS_BITS - 2;
  localparam int OFFB = $clog2(BLOCK_WORDS);
  localparam int L1B  = $clog2(L1_LINES);
  localparam int L2B  = $clog2(L2_SETS);
  localparam int WAYB = $clog2(L2_WAYS);
  localparam int BB   = WAB - OFFB;
  localparam int T1   = BB - L1B;
  localparam int T2   = BB - L2B;
  localparam int M1W  = 2 + T1;
  localparam int M2W  = 2 + T2;
  localparam int SW   = 1 + L2_WAYS * M2W;
  localparam int CNTW = OFFB + 1;
  localparam int L1DA = L1B + OFFB;
  localparam int L2DA = L2B + WAYB + OFFB;

  // memories
  logic [DATA_W-1:0] l1_data [L1_LINES*BLOCK_WORDS];
  logic [M1W-1:0]    l1_meta [L1_LINES];
  logic [DATA_W-1:0] l2_data [L2_SETS*L2_WAYS*BLOCK_WORDS];
  logic [SW-1:0]     l2_set  [L2_SETS];
  logic [DATA_W-1:0] bk_mem  [2**WAB];

  logic [DATA_W-1:0] l1d_q, l2d_q, memd_q;
  logic [M1W-1:0]    l1m_q;
  logic [SW-1:0]     sm_q;

  // memory ports
  logic            l1d_we, l2d_we, mem_we, l1m_we, sm_we;
  logic [L1DA-1:0] l1d_ra, l1d_wa;
  logic [L2DA-1:0] l2d_ra, l2d_wa;
  logic [WAB-1:0]  mem_ra, mem_wa;
  logic [L1B-1:0]  l1m_wa;
  logic [L2B-1:0]  sm_wa;
  logic [DATA_W-1:0] l1d_wd, l2d_wd, mem_wd;
  logic [M1W-1:0]  l1m_wd;
  logic [SW-1:0]   sm_wd;

  // control
  state_t          state_r, state_nxt;
  logic [WAB-1:0]  clr_r;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [15:0]     time_add;
  logic            out_valid_r, out_valid_nxt;
  rsp_t            out_rsp_r, rsp_nxt;

  // request payload
  logic              op_wr_r;
  logic [DATA_W-1:0] wdata_r;
  logic [BB-1:0]     blk_r, l2_blk_r, mem_blk_r;
  logic [OFFB-1:0]   off_r;
  logic              l1_dirty_r, l2_store_r;
  logic [SW-1:0]     set_r, set_fin;
  logic [WAYB-1:0]   way_r, way_sel;
  copy_t             ck_r;

  lat_t lat;

  tlwc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .lat     (lat)
  );

  // request decode
  logic [63:0]     addr64;
  logic            addr_err, accept, is_rw;
  logic [WAB-1:0]  in_wa;
  assign addr64   = 64'(in_req.address);
  assign addr_err = (addr64 >> ADDRESS_BITS) != 64'd0;
  assign in_wa    = addr64[WAB+1:2];
  assign accept   = start && !busy;
  assign is_rw    = (in_req.operation == OP_READ) || (in_req.operation == OP_WRITE);

  logic [L1B-1:0] idx;
  logic [T1-1:0]  tag1;
  logic [L2B-1:0] l2set;
  logic [T2-1:0]  l2tag;
  assign idx   = blk_r[L1B-1:0];
  assign tag1  = blk_r[BB-1:L1B];
  assign l2set = l2_blk_r[L2B-1:0];
  assign l2tag = l2_blk_r[BB-1:L2B];

  // L1 tag check
  logic l1_valid, l1_hit;
  assign l1_valid = l1m_q[M1W-1];
  assign l1_hit   = l1_valid && (l1m_q[T1-1:0] == tag1);

  // L2 way selection: hit, else first invalid way, else least recent
  logic [M2W-1:0] m0, m1, vmeta;
  logic           hit0, hit1, l2_hit;
  assign m0     = sm_q[0 +: M2W];
  assign m1     = sm_q[M2W +: M2W];
  assign hit0   = m0[M2W-1] && (m0[T2-1:0] == l2tag);
  assign hit1   = m1[M2W-1] && (m1[T2-1:0] == l2tag);
  assign l2_hit = hit0 || hit1;
  always_comb begin
    if (hit0)            way_sel = WAYB'(0);
    else if (hit1)       way_sel = WAYB'(1);
    else if (!m0[M2W-1]) way_sel = WAYB'(0);
    else if (!m1[M2W-1]) way_sel = WAYB'(1);
    else                 way_sel = ~sm_q[SW-1];
  end
  assign vmeta = way_sel[0] ? m1 : m0;

  // block move counter
  logic [OFFB-1:0] rd_off, wr_off;
  logic            copy_last, copy_wr;
  assign rd_off    = cnt_r[OFFB-1:0];
  assign wr_off    = rd_off - OFFB'(1);
  assign copy_last = cnt_r == CNTW'(BLOCK_WORDS);
  assign copy_wr   = cnt_r != '0;

  // set word at the end of a transfer: recency and dirty on store
  always_comb begin
    set_fin = set_r;
    set_fin[SW-1] = way_r[0];
    if (ck_r == CP_L1_TO_L2) set_fin[int'(way_r)*M2W + M2W - 2] = 1'b1;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:   if (clr_r == '1) state_nxt = ST_IDLE;
      ST_IDLE:    if (accept && is_rw && !addr_err) state_nxt = ST_L1_META;
      ST_L1_META: state_nxt = ST_L1_CHK;
      ST_L1_CHK:  state_nxt = l1_hit ? ST_L1_OP : ST_L2_META;
      ST_L2_META: state_nxt = ST_L2_CHK;
      ST_L2_CHK:  state_nxt = ST_COPY;
      ST_COPY: begin
        if (copy_last) begin
          case (ck_r)
            CP_L1_TO_L2: state_nxt = ST_L2_META;
            CP_L2_TO_L1: state_nxt = ST_L1_OP;
            default:     state_nxt = ST_COPY;
          endcase
        end
      end
      ST_L1_OP:   state_nxt = ST_DONE;
      ST_DONE:    state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // memory control, time increment and result
  always_comb begin
    l1d_we = 1'b0; l2d_we = 1'b0; mem_we = 1'b0; l1m_we = 1'b0; sm_we = 1'b0;
    l1d_ra = {idx, rd_off};
    l1d_wa = {idx, wr_off};
    l1d_wd = l2d_q;
    l2d_ra = {l2set, way_r, rd_off};
    l2d_wa = {l2set, way_r, wr_off};
    l2d_wd = (ck_r == CP_MEM_TO_L2) ? memd_q : l1d_q;
    mem_ra = {l2_blk_r, rd_off};
    mem_wa = {mem_blk_r, wr_off};
    mem_wd = l2d_q;
    l1m_wa = idx;
    l1m_wd = {1'b1, 1'b0, tag1};
    sm_wa  = l2set;
    sm_wd  = set_fin;
    time_add      = 16'd0;
    out_valid_nxt = 1'b0;
    rsp_nxt       = out_rsp_r;
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1; mem_wa = clr_r; mem_wd = '0;
        l1m_we = 1'b1; l1m_wa = clr_r[L1B-1:0]; l1m_wd = '0;
        sm_we  = 1'b1; sm_wa  = clr_r[L2B-1:0]; sm_wd  = '0;
      end
      ST_IDLE: begin
        if (accept && !(is_rw && !addr_err)) begin
          out_valid_nxt         = 1'b1;
          rsp_nxt.read_data     = '0;
          rsp_nxt.address_error = is_rw && addr_err;
        end
      end
      ST_COPY: begin
        case (ck_r)
          CP_L1_TO_L2: begin
            l2d_we = copy_wr;
            if (copy_last) begin
              sm_we = 1'b1; time_add = {8'd0, lat.l2_wr};
            end
          end
          CP_L2_TO_L1: begin
            l1d_we = copy_wr;
            if (copy_last) begin
              sm_we = 1'b1; l1m_we = 1'b1; time_add = {8'd0, lat.l2_rd};
            end
          end
          CP_L2_TO_MEM: begin
            mem_we = copy_wr;
            if (copy_last) time_add = lat.mem_wr;
          end
          CP_MEM_TO_L2: begin
            l2d_we = copy_wr;
            if (copy_last) time_add = lat.mem_rd;
          end
          default: ;
        endcase
      end
      ST_L1_OP: begin
        l1d_ra = {idx, off_r};
        l1d_wa = {idx, off_r};
        l1d_wd = wdata_r;
        l1d_we = op_wr_r;
        l1m_we = 1'b1;
        l1m_wd = {1'b1, op_wr_r | l1_dirty_r, tag1};
        time_add = op_wr_r ? {8'd0, lat.l1_wr} : {8'd0, lat.l1_rd};
      end
      ST_DONE: begin
        out_valid_nxt         = 1'b1;
        rsp_nxt.read_data     = op_wr_r ? '0 : l1d_q;
        rsp_nxt.address_error = 1'b0;
      end
      default: ;
    endcase
    if (state_r == ST_IDLE && accept && in_req.operation == OP_CLEAR)
      time_nxt = '0;
    else
      time_nxt = time_r + TIME_W'(time_add);
    rsp_nxt.total_time = time_nxt;
  end

  assign cnt_nxt = (state_r == ST_COPY && !copy_last) ? cnt_r + CNTW'(1) : '0;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= (state_r == ST_CLEAR) ? clr_r + WAB'(1) : clr_r;
      cnt_r       <= cnt_nxt;
      time_r      <= time_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request and walk registers
  always_ff @(posedge clk) begin
    out_rsp_r <= rsp_nxt;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_wr_r <= in_req.operation == OP_WRITE;
          wdata_r <= in_req.write_data;
          blk_r   <= in_wa[WAB-1:OFFB];
          off_r   <= in_wa[OFFB-1:0];
        end
      end
      ST_L1_CHK: begin
        l1_dirty_r <= l1_hit && l1m_q[M1W-2];
        if (!l1_hit && l1_valid && l1m_q[M1W-2]) begin
          l2_blk_r   <= {l1m_q[T1-1:0], idx};
          l2_store_r <= 1'b1;
        end else begin
          l2_blk_r   <= blk_r;
          l2_store_r <= 1'b0;
        end
      end
      ST_L2_CHK: begin
        set_r     <= sm_q;
        way_r     <= way_sel;
        mem_blk_r <= {vmeta[T2-1:0], l2set};
        if (l2_hit)
          ck_r <= l2_store_r ? CP_L1_TO_L2 : CP_L2_TO_L1;
        else if (vmeta[M2W-1] && vmeta[M2W-2])
          ck_r <= CP_L2_TO_MEM;
        else
          ck_r <= CP_MEM_TO_L2;
      end
      ST_COPY: begin
        if (copy_last) begin
          case (ck_r)
            CP_L2_TO_MEM: ck_r <= CP_MEM_TO_L2;
            CP_MEM_TO_L2: begin
              ck_r <= l2_store_r ? CP_L1_TO_L2 : CP_L2_TO_L1;
              set_r[int'(way_r)*M2W +: M2W] <= {1'b1, 1'b0, l2tag};
            end
            CP_L1_TO_L2: begin
              l2_blk_r   <= blk_r;
              l2_store_r <= 1'b0;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // synchronous memories, registered read
  always_ff @(posedge clk) begin
    if (l1d_we) l1_data[l1d_wa] <= l1d_wd;
    l1d_q <= l1_data[l1d_ra];
  end

  always_ff @(posedge clk) begin
    if (l2d_we) l2_data[l2d_wa] <= l2d_wd;
    l2d_q <= l2_data[l2d_ra];
  end

  always_ff @(posedge clk) begin
    if (mem_we) bk_mem[mem_wa] <= mem_wd;
    memd_q <= bk_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (l1m_we) l1_meta[l1m_wa] <= l1m_wd;
    l1m_q <= l1_meta[idx];
  end

  always_ff @(posedge clk) begin
    if (sm_we) l2_set[sm_wa] <= sm_wd;
    sm_q <= l2_set[l2set];
  end

  assign busy      = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // checks
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while a request is in flight");

  a_rw_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_rw && !addr_err) |=> (state_r == ST_L1_META) && !out_valid)
    else $error("cache request did not start a lookup");

  a_clear_time: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req.operation == OP_CLEAR) |=> out_valid && out_rsp.total_time == '0)
    else $error("clear request did not zero the time counter");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COPY) |-> (cnt_r <= CNTW'(BLOCK_WORDS)))
    else $error("block move counter overran");

endmodule
`default_nettype wire

// ----- rtl/core/tlwc_cfg_regs.sv -----
`default_nettype none
module tlwc_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output tlwc_pkg::lat_t    lat
);
  import tlwc_pkg::*;

  lat_t       lat_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;
  assign lat     = lat_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r.l1_rd  <= RST_L1_LAT;
      lat_r.l1_wr  <= RST_L1_LAT;
      lat_r.l2_rd  <= RST_L2_LAT;
      lat_r.l2_wr  <= RST_L2_LAT;
      lat_r.mem_rd <= RST_MEM_LAT;
      lat_r.mem_wr <= RST_MEM_LAT;
    end else if (wr_en) begin
      case (reg_idx)
        REG_L1_RD:  lat_r.l1_rd  <= pwdata[7:0];
        REG_L1_WR:  lat_r.l1_wr  <= pwdata[7:0];
        REG_L2_RD:  lat_r.l2_rd  <= pwdata[7:0];
        REG_L2_WR:  lat_r.l2_wr  <= pwdata[7:0];
        REG_MEM_RD: lat_r.mem_rd <= pwdata[15:0];
        REG_MEM_WR: lat_r.mem_wr <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_L1_RD:  prdata = {24'd0, lat_r.l1_rd};
      REG_L1_WR:  prdata = {24'd0, lat_r.l1_wr};
      REG_L2_RD:  prdata = {24'd0, lat_r.l2_rd};
      REG_L2_WR:  prdata = {24'd0, lat_r.l2_wr};
      REG_MEM_RD: prdata = {16'd0, lat_r.mem_rd};
      REG_MEM_WR: prdata = {16'd0, lat_r.mem_wr};
      default:    prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tlwc_pkg::*;

  localparam int BLK_WORDS  = 16;
  localparam int L1_NLINES  = 256;
  localparam int L2_NSETS   = 512;
  localparam int MEM_NWORDS = 1 << (ADDR_W - 2);
  localparam int IDLE_LIMIT = 1200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  req_t        in_req = '0;
  logic        out_valid;
  rsp_t        out_rsp;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  two_level_writeback_cache dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_rsp(out_rsp), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always #4 clk = ~clk;

  // predictor state: latencies, both cache levels, memory, time counter
  lat_t        lat;
  int unsigned l1_data [0:L1_NLINES*BLK_WORDS-1];
  int unsigned l1_tag [0:L1_NLINES-1];
  bit          l1_vld [0:L1_NLINES-1];
  bit          l1_dty [0:L1_NLINES-1];
  int unsigned l2_data [0:L2_NSETS*2*BLK_WORDS-1];
  int unsigned l2_tag [0:L2_NSETS*2-1];
  bit          l2_vld [0:L2_NSETS*2-1];
  bit          l2_dty [0:L2_NSETS*2-1];
  bit          l2_mru [0:L2_NSETS-1];
  int unsigned mem_words [0:MEM_NWORDS-1];
  int unsigned clock_acc;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   errors = 0;
  int   n_reads = 0, n_writes = 0, n_clears = 0, n_other = 0, n_phases = 0;
  bit   quiet = 1'b0;
  int   gap_left = 0;
  int   idle_cycles = 0;

  // move one block between an L2 line and memory
  function automatic void mem_move(int unsigned blk, int unsigned line, bit to_mem);
    for (int i = 0; i < BLK_WORDS; i++) begin
      if (to_mem) mem_words[blk*BLK_WORDS+i] = l2_data[line*BLK_WORDS+i];
      else l2_data[line*BLK_WORDS+i] = mem_words[blk*BLK_WORDS+i];
    end
    clock_acc += to_mem ? lat.mem_wr : lat.mem_rd;
  endfunction

  // L2 block access for L1 line idx; store moves L1 -> L2
  function automatic void l2_block(int unsigned blk, int unsigned idx, bit store);
    int unsigned set, tg, way, line;
    bit hit;
    set = blk % L2_NSETS;
    tg = blk / L2_NSETS;
    hit = 1'b0;
    way = 0;
    for (int w = 0; w < 2; w++) begin
      if (!hit && l2_vld[set*2+w] && l2_tag[set*2+w] == tg) begin
        hit = 1'b1;
        way = w;
      end
    end
    if (!hit) begin
      if (!l2_vld[set*2]) way = 0;
      else if (!l2_vld[set*2+1]) way = 1;
      else way = l2_mru[set] ? 0 : 1;
      line = set*2 + way;
      if (l2_vld[line] && l2_dty[line]) mem_move(l2_tag[line]*L2_NSETS + set, line, 1'b1);
      mem_move(blk, line, 1'b0);
      l2_vld[line] = 1'b1;
      l2_dty[line] = 1'b0;
      l2_tag[line] = tg;
    end
    line = set*2 + way;
    for (int i = 0; i < BLK_WORDS; i++) begin
      if (store) l2_data[line*BLK_WORDS+i] = l1_data[idx*BLK_WORDS+i];
      else l1_data[idx*BLK_WORDS+i] = l2_data[line*BLK_WORDS+i];
    end
    if (store) begin
      l2_dty[line] = 1'b1;
      clock_acc += lat.l2_wr;
    end else begin
      clock_acc += lat.l2_rd;
    end
    l2_mru[set] = way[0];
  endfunction

  // expected result of one request
  function automatic rsp_t cache_response(req_t r);
    rsp_t o;
    int unsigned blk, off, idx, tg;
    o = '0;
    if (r.operation == OP_CLEAR) begin
      clock_acc = 0;
    end else if (r.operation == OP_READ || r.operation == OP_WRITE) begin
      blk = r.address[ADDR_W-1:2] / BLK_WORDS;
      off = r.address[ADDR_W-1:2] % BLK_WORDS;
      idx = blk % L1_NLINES;
      tg = blk / L1_NLINES;
      if (!(l1_vld[idx] && l1_tag[idx] == tg)) begin
        if (l1_vld[idx] && l1_dty[idx]) l2_block(l1_tag[idx]*L1_NLINES + idx, idx, 1'b1);
        l2_block(blk, idx, 1'b0);
        l1_vld[idx] = 1'b1;
        l1_dty[idx] = 1'b0;
        l1_tag[idx] = tg;
      end
      if (r.operation == OP_WRITE) begin
        l1_data[idx*BLK_WORDS+off] = r.write_data;
        l1_dty[idx] = 1'b1;
        clock_acc += lat.l1_wr;
      end else begin
        clock_acc += lat.l1_rd;
        o.read_data = l1_data[idx*BLK_WORDS+off];
      end
    end
    o.total_time = clock_acc;
    o.address_error = 1'b0;
    return o;
  endfunction

  function automatic req_t make_req(logic [1:0] op, logic [ADDR_W-1:0] a, logic [31:0] d);
    req_t r;
    r.operation = op;
    r.address = a;
    r.write_data = d;
    return r;
  endfunction

  // random request: mostly a few blocks that fight over L1 lines and L2 sets
  function automatic req_t rand_req();
    int unsigned p, blk;
    logic [1:0] op;
    logic [ADDR_W-1:0] a;
    p = $urandom_range(0, 99);
    if (p < 45) op = OP_READ;
    else if (p < 90) op = OP_WRITE;
    else if (p < 95) op = OP_CLEAR;
    else op = 2'd3;
    if ($urandom_range(0, 9) < 8) begin
      blk = $urandom_range(0, 15) * L1_NLINES + $urandom_range(0, 3);
      a = ADDR_W'(blk * BLK_WORDS * 4 + $urandom_range(0, 63));
    end else begin
      a = ADDR_W'($urandom);
    end
    return make_req(op, a, $urandom);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_rsps.push_back(cache_response(in_req));
        case (in_req.operation)
          OP_READ:  n_reads++;
          OP_WRITE: n_writes++;
          OP_CLEAR: n_clears++;
          default:  n_other++;
        endcase
        if (!quiet && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 12);
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          start <= 1'b1;
          in_req <= pending_reqs.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    rsp_t e;
    if (rst_n && out_valid) begin
      if (expected_rsps.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = expected_rsps.pop_front();
        if (out_rsp.read_data !== e.read_data) begin
          $error("read_data expected %h actual %h", e.read_data, out_rsp.read_data);
          errors++;
        end
        if (out_rsp.total_time !== e.total_time) begin
          $error("total_time expected %0d actual %0d", e.total_time, out_rsp.total_time);
          errors++;
        end
        if (out_rsp.address_error !== e.address_error) begin
          $error("address_error expected %b actual %b", e.address_error,
                 out_rsp.address_error);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with no request or result accepted
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_rsps.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || start);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_L1_RD:  lat.l1_rd = v[7:0];
      REG_L1_WR:  lat.l1_wr = v[7:0];
      REG_L2_RD:  lat.l2_rd = v[7:0];
      REG_L2_WR:  lat.l2_wr = v[7:0];
      REG_MEM_RD: lat.mem_rd = v[15:0];
      REG_MEM_WR: lat.mem_wr = v[15:0];
      default: ;
    endcase
  endtask

  task automatic set_latencies(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                               logic [7:0] d, logic [15:0] e, logic [15:0] f);
    logic [15:0] junk;
    junk = 16'($urandom);
    reg_write(REG_L1_RD, {junk, 8'($urandom), a});
    reg_write(REG_L1_WR, {junk, 8'($urandom), b});
    reg_write(REG_L2_RD, {junk, 8'($urandom), c});
    reg_write(REG_L2_WR, {junk, 8'($urandom), d});
    reg_write(REG_MEM_RD, {junk, e});
    reg_write(REG_MEM_WR, {junk, f});
    n_phases++;
  endtask

  initial begin
    lat = '{l1_rd: RST_L1_LAT, l1_wr: RST_L1_LAT, l2_rd: RST_L2_LAT, l2_wr: RST_L2_LAT,
            mem_rd: RST_MEM_LAT, mem_wr: RST_MEM_LAT};
    clock_acc = 0;
    for (int i = 0; i < MEM_NWORDS; i++) mem_words[i] = 0;
    for (int i = 0; i < L1_NLINES*BLK_WORDS; i++) l1_data[i] = 0;
    for (int i = 0; i < L2_NSETS*2*BLK_WORDS; i++) l2_data[i] = 0;
    for (int i = 0; i < L1_NLINES; i++) begin
      l1_tag[i] = 0; l1_vld[i] = 0; l1_dty[i] = 0;
    end
    for (int i = 0; i < L2_NSETS*2; i++) begin
      l2_tag[i] = 0; l2_vld[i] = 0; l2_dty[i] = 0;
    end
    for (int i = 0; i < L2_NSETS; i++) l2_mru[i] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, every operation, L1 and L2 evictions
    pending_reqs.push_back(make_req(OP_READ, '0, '0));
    pending_reqs.push_back(make_req(OP_WRITE, '0, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(OP_READ, 20'h00003, '0));
    pending_reqs.push_back(make_req(OP_WRITE, 20'hFFFFF, 32'h8000_0001));
    pending_reqs.push_back(make_req(OP_READ, 20'hFFFFC, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(OP_WRITE, 20'h04000, 32'h1234_5678));
    pending_reqs.push_back(make_req(OP_READ, 20'h00000, '0));
    pending_reqs.push_back(make_req(OP_WRITE, 20'h08000, 32'hA5A5_5A5A));
    pending_reqs.push_back(make_req(OP_WRITE, 20'h10000, 32'h0F0F_F0F0));
    pending_reqs.push_back(make_req(OP_WRITE, 20'h18000, 32'hDEAD_BEEF));
    pending_reqs.push_back(make_req(OP_READ, 20'h00000, '0));
    pending_reqs.push_back(make_req(OP_READ, 20'h08000, '0));
    pending_reqs.push_back(make_req(OP_READ, 20'h04000, '0));
    pending_reqs.push_back(make_req(2'd3, 20'hFFFFF, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(OP_CLEAR, 20'hFFFFF, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(OP_READ, 20'h0003C, '0));
    pending_reqs.push_back(make_req(OP_CLEAR, '0, '0));
    pending_reqs.push_back(make_req(OP_READ, 20'h18000, '0));
    wait_drained();

    // random phases over several latency settings, last one without gaps
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_latencies(8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF);
        1: set_latencies(8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0);
        2: set_latencies(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         16'($urandom), 16'($urandom));
        3: set_latencies(8'd1, 8'd1, 8'd4, 8'd4, 16'd100, 16'd100);
        default: set_latencies(8'($urandom), 8'd255, 8'd0, 8'($urandom),
                               16'hFFFF, 16'($urandom));
      endcase
      quiet = (ph == 4);
      for (int k = 0; k < 206; k++) pending_reqs.push_back(rand_req());
      wait_drained();
    end

    repeat (20) @(posedge clk);
    $display("covered %0d reads, %0d writes, %0d clears, %0d unused ops", n_reads,
             n_writes, n_clears, n_other);
    $display("over %0d latency settings including all-max and all-zero", n_phases);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
